/* rtl/core/ksq_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and field layout for the keyed shift queue
package ksq_pkg;

  // request operation codes (tuser of the input channel)
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_FIND = 2'd2;
  localparam logic [1:0] CMD_DEL  = 2'd3;

  // result status codes (tuser of the output channel)
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int ITEM_KEY_W = 64;
  localparam int DUR_W      = 8;
  localparam int PRICE_W    = 20;
  localparam int HOLD_W     = 8;
  localparam int POS_W      = 4;
  localparam int SLOT_W     = 5;
  localparam int FILL_W     = 5;

  // input tdata layout
  localparam int IN_DUR_LSB   = ITEM_KEY_W;
  localparam int IN_PRICE_LSB = IN_DUR_LSB + DUR_W;
  localparam int IN_HOLD_LSB  = IN_PRICE_LSB + PRICE_W;
  localparam int IN_POS_LSB   = IN_HOLD_LSB + HOLD_W;
  localparam int IN_TDATA_W   = IN_POS_LSB + POS_W;

  // output tdata layout
  localparam int OUT_SLOT_LSB  = ITEM_KEY_W + DUR_W + PRICE_W + HOLD_W;
  localparam int OUT_FOUND_LSB = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_FILL_LSB  = OUT_FOUND_LSB + 1;
  localparam int OUT_USED_W    = OUT_FILL_LSB + FILL_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;

  // default sizing
  localparam int DEF_DEPTH     = 16;
  localparam int DEF_KEY_WIDTH = 64;

  // controller to datapath commands
  typedef struct packed {
    logic             lat_in;
    logic             clr_res;
    logic             set_status;
    logic [STAT_W-1:0] status_code;
    logic             enq_write;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             ptr_zero;
    logic             ptr_pos;
    logic             rd_issue;
    logic             cap_rec;
    logic             shift_write;
    logic             set_found;
    logic             set_notfound;
    logic             out_load;
  } ksq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             empty;
    logic             pos_bad;
    logic             ptr_end;
    logic             rd_vld;
    logic             rd_match;
    logic             rd_is_base;
    logic             out_free;
  } ksq_stat_t;

endpackage

/* rtl/core/keyed_shift_queue.sv */
`timescale 1ns / 1ps
// keyed shift queue: bounded record fifo with find by key and delete at slot
//
// Requests arrive on the in_ stream: tuser carries the operation (enqueue,
// dequeue, find by key, delete at slot), tdata the key, record fields and slot.
// Every request yields exactly one result on the out_ stream: tuser carries
// the status, tdata the removed record, the find outcome and the fill count.
// One request is taken at a time; in_tready is high only between requests.
// Each request runs through the execute state, then a find or shift walk
// where needed, then the done state, which loads the result into the output
// register; a full enqueue, an empty dequeue and a bad slot are refused
// in the execute state.
// in_tready returns the cycle after the result is loaded, so a new request
// is taken only once the last one has its result loaded.
// The find walk and the shift walk go one slot per cycle through the single
// read port of the record store; the read data is registered before use.
// A finished result waits in the output register while the receiver stalls;
// the next request is still accepted and runs until its own result is ready,
// then holds until the register frees.
// Reset empties the queue (count cleared); stored records need no clearing.
module keyed_shift_queue import ksq_pkg::*; #(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // key[63:0], item_duration[71:64], item_price[91:72], item_hold[99:92],
  // position[103:100]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_key[63:0], out_duration[71:64], out_price[91:72], out_hold[99:92],
  // found_slot[104:100], found[105], fill_count[110:106], zero[111]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]      out_tuser
);

  ksq_cmd_t  cmd;
  ksq_stat_t stat;

  // sequencer
  ksq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and result path
  ksq_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

  // a held result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over a pending one");

  // append and shift never contend for the write port
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.enq_write && (cmd.shift_write || cmd.cap_rec)))
    else $error("store write conflict");

  // one request at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  // a refused request carries no record and no find hit
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != ST_OK)) |->
      (out_tdata[OUT_FOUND_LSB] == 1'b0) && (out_tdata[ITEM_KEY_W-1:0] == '0))
    else $error("refused request returned data");

endmodule

/* rtl/core/ksq_ctrl.sv */
`timescale 1ns / 1ps
// sequencing state machine of the keyed shift queue
module ksq_ctrl import ksq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ksq_stat_t stat,
  output ksq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.lat_in = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.clr_res = 1'b1;
        unique case (stat.op)
          CMD_ENQ: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.enq_write = 1'b1;
              cmd.cnt_inc   = 1'b1;
            end
            state_nxt = S_DONE;
          end
          CMD_DEQ: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_nxt       = S_DONE;
            end else begin
              cmd.ptr_zero = 1'b1;
              state_nxt    = S_SHIFT;
            end
          end
          CMD_FIND: begin
            cmd.ptr_zero = 1'b1;
            state_nxt    = S_FIND;
          end
          CMD_DEL: begin
            if (stat.pos_bad) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_RANGE;
              state_nxt       = S_DONE;
            end else begin
              cmd.ptr_pos = 1'b1;
              state_nxt   = S_SHIFT;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // one slot read per cycle, compare on the registered data
      S_FIND: begin
        if (stat.rd_vld && stat.rd_match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_DONE;
        end else if (!stat.ptr_end) begin
          cmd.rd_issue = 1'b1;
        end else if (!stat.rd_vld) begin
          cmd.set_notfound = 1'b1;
          state_nxt        = S_DONE;
        end
      end
      // first read is the removed record, later reads move down one slot
      S_SHIFT: begin
        if (!stat.ptr_end) begin
          cmd.rd_issue = 1'b1;
        end
        if (stat.rd_vld) begin
          if (stat.rd_is_base) begin
            cmd.cap_rec = 1'b1;
          end else begin
            cmd.shift_write = 1'b1;
          end
        end
        if (stat.ptr_end && !stat.rd_vld) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/ksq_dpath.sv */
`timescale 1ns / 1ps
// record store, pointers, result staging and output register of the queue
module ksq_dpath import ksq_pkg::*; #(
  parameter int DEPTH     = DEF_DEPTH,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]       in_tuser,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STAT_W-1:0]      out_tuser,
  input  ksq_cmd_t               cmd,
  output ksq_stat_t              stat
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int REC_W  = KEY_WIDTH + DUR_W + PRICE_W + HOLD_W;

  // latched request
  logic [CMD_W-1:0]     op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [DUR_W-1:0]     dur_r;
  logic [PRICE_W-1:0]   price_r;
  logic [HOLD_W-1:0]    hold_r;
  logic [POS_W-1:0]     pos_r;

  // queue control
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  ptr_r;
  logic [ADDR_W-1:0] base_r;
  logic [CMP_W-1:0]  pos_ext;

  // record store and its read side
  logic [REC_W-1:0]  mem [DEPTH];
  logic [REC_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              rd_vld_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [REC_W-1:0]  mem_wdata;

  // result staging
  logic [STAT_W-1:0] res_status_r;
  logic [REC_W-1:0]  res_rec_r;
  logic [CNT_W-1:0]  res_slot_r;
  logic              res_found_r;

  // output register
  logic                   out_vld_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic [CNT_W+SLOT_W-1:0] slot_wide;
  logic [CNT_W+FILL_W-1:0] fill_wide;

  // request latch, key trimmed to the stored width
  always_ff @(posedge clk) begin
    if (cmd.lat_in) begin
      op_r    <= in_tuser;
      key_r   <= in_tdata[KEY_WIDTH-1:0];
      dur_r   <= in_tdata[IN_DUR_LSB +: DUR_W];
      price_r <= in_tdata[IN_PRICE_LSB +: PRICE_W];
      hold_r  <= in_tdata[IN_HOLD_LSB +: HOLD_W];
      pos_r   <= in_tdata[IN_POS_LSB +: POS_W];
    end
  end

  assign pos_ext = CMP_W'(pos_r);

  // record count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // walk pointer and the slot being removed
  always_ff @(posedge clk) begin
    if (cmd.ptr_zero) begin
      ptr_r  <= '0;
      base_r <= '0;
    end else if (cmd.ptr_pos) begin
      ptr_r  <= pos_ext[CNT_W-1:0];
      base_r <= pos_ext[ADDR_W-1:0];
    end else if (cmd.rd_issue) begin
      ptr_r  <= ptr_r + CNT_W'(1);
    end
  end

  // write port: append at the tail, or move a record down one slot
  assign mem_we    = cmd.enq_write | cmd.shift_write;
  assign mem_waddr = cmd.shift_write ? (rd_addr_r - ADDR_W'(1)) : cnt_r[ADDR_W-1:0];
  assign mem_wdata = cmd.shift_write ? rd_data_r : {hold_r, price_r, dur_r, key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[ptr_r[ADDR_W-1:0]];
      rd_addr_r <= ptr_r[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_issue;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.clr_res) begin
      res_status_r <= ST_OK;
      res_rec_r    <= '0;
      res_slot_r   <= '0;
      res_found_r  <= 1'b0;
    end
    if (cmd.set_status) begin
      res_status_r <= cmd.status_code;
    end
    if (cmd.cap_rec) begin
      res_rec_r <= rd_data_r;
    end
    if (cmd.set_found) begin
      res_found_r <= 1'b1;
      res_slot_r  <= CNT_W'(rd_addr_r);
    end
    if (cmd.set_notfound) begin
      res_slot_r <= cnt_r;
    end
  end

  // result packing, slot and count cut to the port width
  assign slot_wide = {{SLOT_W{1'b0}}, res_slot_r};
  assign fill_wide = {{FILL_W{1'b0}}, cnt_r};
  assign out_data_nxt = {{OUT_PAD_W{1'b0}},
                         fill_wide[FILL_W-1:0],
                         res_found_r,
                         slot_wide[SLOT_W-1:0],
                         res_rec_r[KEY_WIDTH+DUR_W+PRICE_W +: HOLD_W],
                         res_rec_r[KEY_WIDTH+DUR_W +: PRICE_W],
                         res_rec_r[KEY_WIDTH +: DUR_W],
                         ITEM_KEY_W'(res_rec_r[KEY_WIDTH-1:0])};

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // status towards the controller
  always_comb begin
    stat            = '0;
    stat.op         = op_r;
    stat.full       = (cnt_r == CNT_W'(DEPTH));
    stat.empty      = (cnt_r == '0);
    stat.pos_bad    = (pos_ext >= CMP_W'(cnt_r));
    stat.ptr_end    = (ptr_r >= cnt_r);
    stat.rd_vld     = rd_vld_r;
    stat.rd_match   = (rd_data_r[KEY_WIDTH-1:0] == key_r);
    stat.rd_is_base = (rd_addr_r == base_r);
    stat.out_free   = !out_vld_r || out_tready;
  end

endmodule
